@@ src/utt_pkg.sv @@
// utt_pkg: shared constants, queue entry type and UTF-8 helper functions
// for the UTF-16 to UTF-8 transcoder. No dependencies.

package utt_pkg;

  // code point and surrogate constants
  localparam logic [15:0] REPLACEMENT_CP  = 16'hFFFD;
  localparam logic [15:0] HI_SURR_MIN     = 16'hD800;
  localparam logic [15:0] HI_SURR_MAX     = 16'hDBFF;
  localparam logic [15:0] LO_SURR_MIN     = 16'hDC00;
  localparam logic [15:0] LO_SURR_MAX     = 16'hDFFF;
  localparam logic [20:0] SUPP_PLANE_BASE = 21'h10000;
  localparam int          SURR_SHIFT      = 10;
  localparam int          UTF8_OFFSET     = 6;

  // utf-8 byte marks
  localparam logic [7:0] CONT_MARK = 8'h80;
  localparam logic [7:0] CONT_MASK = 8'hBF;
  localparam logic [7:0] LEAD_MARK [5] = '{8'h00, 8'h00, 8'hC0, 8'hE0, 8'hF0};

  // register reset and sizes
  localparam logic [15:0] CAPACITY_RESET = 16'hFFFF;
  localparam int          CP_W           = 21;
  localparam int          LEN_W          = 3;
  localparam int          FIFO_DEPTH     = 2;
  localparam int          FIFO_AW        = $clog2(FIFO_DEPTH);

  // byte lengths
  localparam logic [LEN_W-1:0] LEN_1 = 3'd1;
  localparam logic [LEN_W-1:0] LEN_2 = 3'd2;
  localparam logic [LEN_W-1:0] LEN_3 = 3'd3;
  localparam logic [LEN_W-1:0] LEN_4 = 3'd4;

  // one classified input item: up to two characters to encode
  typedef struct packed {
    logic [CP_W-1:0]  a_cp;
    logic [LEN_W-1:0] a_len;
    logic             a_en;
    logic [CP_W-1:0]  b_cp;
    logic [LEN_W-1:0] b_len;
    logic             b_en;
    logic             last_unit;
  } char_entry_t;

  // number of utf-8 bytes for a code point
  function automatic logic [LEN_W-1:0] utf8_len(input logic [CP_W-1:0] cp);
    if (cp <= 21'h7F) begin
      return LEN_1;
    end else if (cp <= 21'h7FF) begin
      return LEN_2;
    end else if (cp <= 21'hFFFF) begin
      return LEN_3;
    end
    return LEN_4;
  endfunction

  // byte j of the utf-8 form of cp, len bytes long
  function automatic logic [7:0] utf8_byte(input logic [CP_W-1:0] cp,
                                           input logic [LEN_W-1:0] len,
                                           input logic [1:0] j);
    logic [1:0] rem;
    logic [7:0] b;
    rem = 2'(len - LEN_1) - j;
    b   = 8'h00;
    if (j == 2'd0) begin
      case (len)
        LEN_1:   b = {1'b0, cp[6:0]};
        LEN_2:   b = LEAD_MARK[2] | {3'b000, cp[10:6]};
        LEN_3:   b = LEAD_MARK[3] | {4'h0, cp[15:12]};
        LEN_4:   b = LEAD_MARK[4] | {5'h00, cp[20:18]};
        default: b = 8'h00;
      endcase
    end else begin
      case (rem)
        2'd0:    b = (CONT_MARK | {2'b00, cp[5:0]}) & CONT_MASK;
        2'd1:    b = (CONT_MARK | {2'b00, cp[11:6]}) & CONT_MASK;
        2'd2:    b = (CONT_MARK | {2'b00, cp[17:12]}) & CONT_MASK;
        default: b = CONT_MARK;
      endcase
    end
    return b;
  endfunction

endpackage

@@ src/utt_front.sv @@
// utt_front: accepts UTF-16 units, pairs surrogates and turns each unit
// into a queue entry of up to two code points. Depends on utt_pkg.

module utt_front
  import utt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [15:0] in_code_unit,
  input  logic        in_last_unit,
  input  logic        q_ready,
  output logic        q_push,
  output char_entry_t q_entry
);

  logic [9:0]      pend_high_r, pend_high_nxt;
  logic            pend_valid_r, pend_valid_nxt;
  logic            unit_low, unit_high;
  logic [CP_W-1:0] pair_cp;
  logic [CP_W-1:0] rest_cp;
  logic            rest_en;
  logic [CP_W-1:0] a_cp, b_cp;
  logic            a_en, b_en;

  assign q_push = in_valid && q_ready;

  // unit classification
  assign unit_low  = (in_code_unit >= LO_SURR_MIN) && (in_code_unit <= LO_SURR_MAX);
  assign unit_high = (in_code_unit >= HI_SURR_MIN) && (in_code_unit <= HI_SURR_MAX);
  assign pair_cp   = {1'b0, pend_high_r, in_code_unit[9:0]} + SUPP_PLANE_BASE;

  // character from the unit itself, with nothing held
  always_comb begin
    rest_cp = {5'h00, in_code_unit};
    rest_en = 1'b1;
    if (unit_low) begin
      rest_cp = {5'h00, REPLACEMENT_CP};
    end else if (unit_high) begin
      rest_cp = {5'h00, REPLACEMENT_CP};
      rest_en = in_last_unit;
    end
  end

  // combine with a held high surrogate; code point zero yields nothing
  always_comb begin
    a_cp = rest_cp;
    a_en = rest_en && (rest_cp != '0);
    b_cp = rest_cp;
    b_en = 1'b0;
    if (pend_valid_r) begin
      if (unit_low) begin
        a_cp = pair_cp;
        a_en = 1'b1;
      end else begin
        a_cp = {5'h00, REPLACEMENT_CP};
        a_en = 1'b1;
        b_en = rest_en && (rest_cp != '0);
      end
    end
  end

  always_comb begin
    q_entry.a_cp      = a_cp;
    q_entry.a_len     = utf8_len(a_cp);
    q_entry.a_en      = a_en;
    q_entry.b_cp      = b_cp;
    q_entry.b_len     = utf8_len(b_cp);
    q_entry.b_en      = b_en;
    q_entry.last_unit = in_last_unit;
  end

  // held surrogate update
  always_comb begin
    pend_high_nxt  = pend_high_r;
    pend_valid_nxt = pend_valid_r;
    if (q_push) begin
      pend_valid_nxt = 1'b0;
      if ((!pend_valid_r || !unit_low) && unit_high && !in_last_unit) begin
        pend_valid_nxt = 1'b1;
        pend_high_nxt  = in_code_unit[9:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
    end else begin
      pend_valid_r <= pend_valid_nxt;
    end
    pend_high_r <= pend_high_nxt;
  end

endmodule

@@ src/utt_fifo.sv @@
// utt_fifo: short register queue of classified entries between the front
// and the byte emitter. Depends on utt_pkg.

module utt_fifo
  import utt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  char_entry_t push_entry,
  output logic        not_full,
  input  logic        pop,
  output logic        not_empty,
  output char_entry_t head
);

  char_entry_t        mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]   count_r;

  assign not_full  = (count_r != (FIFO_AW+1)'(FIFO_DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

@@ src/utt_back.sv @@
// utt_back: applies the capacity check to each entry and emits the UTF-8 bytes
// one per cycle unless out_ready stalls, via an output register. Depends on utt_pkg.

module utt_back
  import utt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [15:0] capacity,
  input  logic        q_valid,
  input  char_entry_t q_head,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic [15:0] out_byte_position,
  output logic        out_last_of_item
);

  logic             busy_r, busy_nxt;
  logic [CP_W-1:0]  cur_cp_r, cur_cp_nxt;
  logic [LEN_W-1:0] cur_len_r, cur_len_nxt;
  logic [1:0]       idx_r, idx_nxt;
  logic [CP_W-1:0]  sec_cp_r, sec_cp_nxt;
  logic [LEN_W-1:0] sec_len_r, sec_len_nxt;
  logic             sec_en_r, sec_en_nxt;
  logic [15:0]      pos_r, pos_nxt;
  logic [15:0]      plan_bw_r, plan_bw_nxt;
  logic             ov_r, ov_nxt;
  logic [7:0]       ob_r, ob_nxt;
  logic [15:0]      op_r, op_nxt;
  logic             ol_r, ol_nxt;

  logic        advance, final_byte;
  logic        fit_a, fit_b;
  logic [16:0] sum_a, sum_b;
  logic [15:0] base_b;

  assign out_valid         = ov_r;
  assign out_byte          = ob_r;
  assign out_byte_position = op_r;
  assign out_last_of_item  = ol_r;

  assign advance    = busy_r && (!ov_r || out_ready);
  assign final_byte = (idx_r == 2'(cur_len_r - LEN_1));
  assign q_pop      = q_valid && (!busy_r || (advance && final_byte && !sec_en_r));

  // capacity check for both characters of the head entry
  assign sum_a  = {1'b0, plan_bw_r} + 17'(q_head.a_len);
  assign fit_a  = q_head.a_en && (sum_a <= {1'b0, capacity});
  assign base_b = fit_a ? sum_a[15:0] : plan_bw_r;
  assign sum_b  = {1'b0, base_b} + 17'(q_head.b_len);
  assign fit_b  = q_head.b_en && (sum_b <= {1'b0, capacity});

  // byte sequencer and entry load
  always_comb begin
    busy_nxt    = busy_r;
    cur_cp_nxt  = cur_cp_r;
    cur_len_nxt = cur_len_r;
    idx_nxt     = idx_r;
    sec_cp_nxt  = sec_cp_r;
    sec_len_nxt = sec_len_r;
    sec_en_nxt  = sec_en_r;
    pos_nxt     = pos_r;
    plan_bw_nxt = plan_bw_r;
    if (advance) begin
      pos_nxt = pos_r + 16'd1;
      idx_nxt = idx_r + 2'd1;
      if (final_byte) begin
        if (sec_en_r) begin
          cur_cp_nxt  = sec_cp_r;
          cur_len_nxt = sec_len_r;
          sec_en_nxt  = 1'b0;
          idx_nxt     = 2'd0;
        end else begin
          busy_nxt = 1'b0;
        end
      end
    end
    if (q_pop) begin
      busy_nxt    = fit_a || fit_b;
      idx_nxt     = 2'd0;
      pos_nxt     = plan_bw_r;
      cur_cp_nxt  = fit_a ? q_head.a_cp : q_head.b_cp;
      cur_len_nxt = fit_a ? q_head.a_len : q_head.b_len;
      sec_cp_nxt  = q_head.b_cp;
      sec_len_nxt = q_head.b_len;
      sec_en_nxt  = fit_a && fit_b;
      if (q_head.last_unit) begin
        plan_bw_nxt = '0;
      end else if (fit_b) begin
        plan_bw_nxt = sum_b[15:0];
      end else begin
        plan_bw_nxt = base_b;
      end
    end
  end

  // output register
  always_comb begin
    ov_nxt = ov_r;
    ob_nxt = ob_r;
    op_nxt = op_r;
    ol_nxt = ol_r;
    if (advance) begin
      ov_nxt = 1'b1;
      ob_nxt = utf8_byte(cur_cp_r, cur_len_r, idx_r);
      op_nxt = pos_r;
      ol_nxt = final_byte && !sec_en_r;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      sec_en_r  <= 1'b0;
      plan_bw_r <= '0;
      ov_r      <= 1'b0;
    end else begin
      busy_r    <= busy_nxt;
      sec_en_r  <= sec_en_nxt;
      plan_bw_r <= plan_bw_nxt;
      ov_r      <= ov_nxt;
    end
    cur_cp_r  <= cur_cp_nxt;
    cur_len_r <= cur_len_nxt;
    idx_r     <= idx_nxt;
    sec_cp_r  <= sec_cp_nxt;
    sec_len_r <= sec_len_nxt;
    pos_r     <= pos_nxt;
    ob_r      <= ob_nxt;
    op_r      <= op_nxt;
    ol_r      <= ol_nxt;
  end

endmodule

@@ src/utf16_to_utf8_transcoder.sv @@
// UTF-16 to UTF-8 transcoder, one code unit in, one UTF-8 byte out per transfer.
// A front stage pairs surrogates and classifies each unit into at most two
// characters; a two-entry queue feeds a byte emitter that checks each character
// against output_capacity and sends its bytes leading byte first through an
// output register. The output side moves one byte per cycle unless out_ready
// stalls it; an item yields zero to six bytes (commonly one to three), and one
// that yields no byte is still popped by the emitter. Input transfers
// continue while earlier bytes drain, as long as the queue has room. The
// capacity register is written through cfg_ and resets to 65535; write it only
// while the block is idle. The last unit of a string clears the byte count and
// any held high surrogate. No clearing pass is needed after reset.
// Depends on utt_pkg, utt_front, utt_fifo and utt_back.

module utf16_to_utf8_transcoder
  import utt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_output_capacity,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_code_unit,
  input  logic        in_last_unit,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic [15:0] out_byte_position,
  output logic        out_last_of_item
);

  logic [15:0] capacity_r;
  logic        q_push, q_pop, q_not_full, q_not_empty;
  char_entry_t q_in, q_head;

  assign cfg_ready = 1'b1;
  assign in_ready  = q_not_full;

  // capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAPACITY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity_r <= cfg_output_capacity;
    end
  end

  utt_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_code_unit (in_code_unit),
    .in_last_unit (in_last_unit),
    .q_ready      (q_not_full),
    .q_push       (q_push),
    .q_entry      (q_in)
  );

  utt_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .not_full   (q_not_full),
    .pop        (q_pop),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  utt_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .capacity          (capacity_r),
    .q_valid           (q_not_empty),
    .q_head            (q_head),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_byte          (out_byte),
    .out_byte_position (out_byte_position),
    .out_last_of_item  (out_last_of_item)
  );

endmodule

@@ test/utt_scoreboard.sv @@
// utt_scoreboard: watches the cfg, in and out channels of the UTF-16 to UTF-8
// transcoder, predicts the UTF-8 bytes of every code unit and compares them.
// Depends on utt_pkg for the surrogate and byte-mark constants.
`timescale 1ns / 100ps

module utt_scoreboard
  import utt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_output_capacity,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [15:0] in_code_unit,
  input  logic        in_last_unit,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_byte,
  input  logic [15:0] out_byte_position,
  input  logic        out_last_of_item,
  output int          mismatch_count,
  output int          bytes_pending,
  output int          units_seen,
  output int          bytes_seen
);

  typedef struct {
    logic [7:0]  data;
    logic [15:0] pos;
    logic        last;
  } utf8_byte_t;

  // predicted bytes, oldest first, and the bytes of the unit being decoded
  utf8_byte_t expected_bytes[$];
  utf8_byte_t unit_bytes[$];

  // predictor state
  logic [15:0] capacity     = CAPACITY_RESET;
  logic [15:0] held_high    = '0;
  logic        high_held    = 1'b0;
  logic [15:0] string_bytes = '0;

  int errors    = 0;
  int level     = 0;
  int n_units   = 0;
  int n_bytes   = 0;

  assign mismatch_count = errors;
  assign bytes_pending  = level;
  assign units_seen     = n_units;
  assign bytes_seen     = n_bytes;

  function automatic logic is_lead(input logic [15:0] u);
    return (u >= HI_SURR_MIN) && (u <= HI_SURR_MAX);
  endfunction

  function automatic logic is_trail(input logic [15:0] u);
    return (u >= LO_SURR_MIN) && (u <= LO_SURR_MAX);
  endfunction

  // one line per mismatch
  task automatic report_mismatch(input string what, input int want, input int got);
    $display("%0t ns mismatch: %s expected %0h got %0h", $time, what, want, got);
    errors++;
  endtask

  // utf-8 bytes of one code point, skipped whole when the string would overflow
  task automatic encode_char(input logic [20:0] cp);
    logic [2:0]  size;
    logic [7:0]  enc [4];
    logic [20:0] v;
    utf8_byte_t  b;
    int          j;
    v = cp;
    if (cp == '0) return;
    if (cp <= 21'h7F) size = 3'd1;
    else if (cp <= 21'h7FF) size = 3'd2;
    else if (cp <= 21'hFFFF) size = 3'd3;
    else size = 3'd4;
    if (17'(string_bytes) + 17'(size) > 17'(capacity)) return;
    for (j = 3; j > 0; j--) begin
      if (j < size) begin
        enc[j] = (v[7:0] | CONT_MARK) & CONT_MASK;
        v = v >> UTF8_OFFSET;
      end
    end
    enc[0] = v[7:0] | LEAD_MARK[size];
    for (j = 0; j < size; j++) begin
      b.data = enc[j];
      b.pos  = string_bytes;
      b.last = 1'b0;
      unit_bytes.push_back(b);
      string_bytes = string_bytes + 16'd1;
    end
  endtask

  // decode one code unit against the held high surrogate
  task automatic transcode_unit(input logic [15:0] u, input logic lst);
    logic [20:0] cp;
    logic        paired;
    unit_bytes.delete();
    paired = 1'b0;
    if (high_held) begin
      high_held = 1'b0;
      if (is_trail(u)) begin
        cp = ((21'(held_high) - 21'(HI_SURR_MIN)) << SURR_SHIFT)
           + (21'(u) - 21'(LO_SURR_MIN)) + SUPP_PLANE_BASE;
        held_high = '0;
        encode_char(cp);
        paired = 1'b1;
      end else begin
        // broken pair: replacement for the held unit, then the new unit alone
        held_high = '0;
        encode_char(21'(REPLACEMENT_CP));
      end
    end
    if (!paired) begin
      if (is_trail(u)) begin
        encode_char(21'(REPLACEMENT_CP));
      end else if (is_lead(u)) begin
        if (lst) begin
          encode_char(21'(REPLACEMENT_CP));
        end else begin
          held_high = u;
          high_held = 1'b1;
        end
      end else begin
        encode_char(21'(u));
      end
    end
    if (unit_bytes.size() > 0) unit_bytes[unit_bytes.size() - 1].last = 1'b1;
    foreach (unit_bytes[k]) expected_bytes.push_back(unit_bytes[k]);
    // end of string clears everything but the capacity
    if (lst) begin
      held_high    = '0;
      high_held    = 1'b0;
      string_bytes = '0;
    end
  endtask

  // watch all three channels at each rising edge
  always @(posedge clk) begin
    utf8_byte_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) capacity = cfg_output_capacity;
      if (in_valid && in_ready) begin
        transcode_unit(in_code_unit, in_last_unit);
        n_units++;
      end
      if (out_valid && out_ready) begin
        n_bytes++;
        if (expected_bytes.size() == 0) begin
          report_mismatch("byte with nothing expected", -1, out_byte);
        end else begin
          want = expected_bytes.pop_front();
          if (out_byte !== want.data)
            report_mismatch("out_byte", want.data, out_byte);
          if (out_byte_position !== want.pos)
            report_mismatch("out_byte_position", want.pos, out_byte_position);
          if (out_last_of_item !== want.last)
            report_mismatch("out_last_of_item", want.last, out_last_of_item);
        end
      end
      level = expected_bytes.size();
    end
  end

endmodule

@@ test/tb_utf16_to_utf8_transcoder.sv @@
// tb_utf16_to_utf8_transcoder: drives code units and capacity writes into the
// transcoder and gives the verdict; utt_scoreboard does the byte checking.
// Depends on utt_pkg, utf16_to_utf8_transcoder and utt_scoreboard.
`timescale 1ns / 100ps

module tb_utf16_to_utf8_transcoder
  import utt_pkg::*;
;

  localparam int DRAIN_CYCLES  = 16;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_UNITS   = 26;

  typedef enum int {
    KIND_ASCII, KIND_TWO_BYTE, KIND_THREE_BYTE, KIND_PAIR,
    KIND_LONE_LOW, KIND_LONE_HIGH, KIND_RAW
  } unit_kind_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_output_capacity;
  logic        in_valid;
  logic        in_ready;
  logic [15:0] in_code_unit;
  logic        in_last_unit;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_byte;
  logic [15:0] out_byte_position;
  logic        out_last_of_item;

  int mismatch_count;
  int bytes_pending;
  int units_seen;
  int bytes_seen;

  bit fast_sender   = 1'b0;
  bit fast_receiver = 1'b0;
  bit hold_receiver = 1'b0;
  int capacity_writes = 0;

  always #6 clk = ~clk;

  utf16_to_utf8_transcoder i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_output_capacity (cfg_output_capacity),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_code_unit        (in_code_unit),
    .in_last_unit        (in_last_unit),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_byte            (out_byte),
    .out_byte_position   (out_byte_position),
    .out_last_of_item    (out_last_of_item)
  );

  utt_scoreboard i_scoreboard (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_output_capacity (cfg_output_capacity),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_code_unit        (in_code_unit),
    .in_last_unit        (in_last_unit),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_byte            (out_byte),
    .out_byte_position   (out_byte_position),
    .out_last_of_item    (out_last_of_item),
    .mismatch_count      (mismatch_count),
    .bytes_pending       (bytes_pending),
    .units_seen          (units_seen),
    .bytes_seen          (bytes_seen)
  );

  // one code unit transfer; valid stays high across back-to-back units
  task automatic send_unit(input logic [15:0] u, input logic lst);
    int gap;
    gap = fast_sender ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_code_unit <= u;
    in_last_unit <= lst;
    in_valid     <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // wait for every predicted byte, then for units that give no byte
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (bytes_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [15:0] value);
    cfg_output_capacity <= value;
    cfg_valid           <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    capacity_writes++;
  endtask

  // mostly well-formed text with random content, plus lone surrogates and noise
  task automatic random_string_units(input int count);
    int         sent;
    int         r;
    unit_kind_t kind;
    logic       lst;
    logic [15:0] u;
    sent = 0;
    while (sent < count) begin
      r = $urandom_range(0, 15);
      if (r < 4) kind = KIND_ASCII;
      else if (r < 6) kind = KIND_TWO_BYTE;
      else if (r < 8) kind = KIND_THREE_BYTE;
      else if (r < 11) kind = KIND_PAIR;
      else if (r < 12) kind = KIND_LONE_LOW;
      else if (r < 13) kind = KIND_LONE_HIGH;
      else kind = KIND_RAW;
      lst = ($urandom_range(0, 5) == 0);
      case (kind)
        KIND_ASCII:      u = 16'($urandom_range(0, 16'h7F));
        KIND_TWO_BYTE:   u = 16'($urandom_range(16'h80, 16'h7FF));
        KIND_THREE_BYTE: begin
          if ($urandom_range(0, 1) == 0) u = 16'($urandom_range(16'h800, 16'hD7FF));
          else u = 16'($urandom_range(16'hE000, 16'hFFFF));
        end
        KIND_PAIR: begin
          send_unit(16'($urandom_range(HI_SURR_MIN, HI_SURR_MAX)), 1'b0);
          sent++;
          u = 16'($urandom_range(LO_SURR_MIN, LO_SURR_MAX));
        end
        KIND_LONE_LOW:   u = 16'($urandom_range(LO_SURR_MIN, LO_SURR_MAX));
        KIND_LONE_HIGH:  u = 16'($urandom_range(HI_SURR_MIN, HI_SURR_MAX));
        default:         u = 16'($urandom());
      endcase
      send_unit(u, lst);
      sent++;
    end
    // close the string so the next capacity starts clean
    send_unit(16'($urandom_range(0, 16'h7F)), 1'b1);
  endtask

  // result side: random stall per byte, one long hold on request
  initial begin
    int stall;
    out_ready = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_receiver) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_receiver = 1'b0;
      end
      stall = fast_receiver ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // stimulus and verdict
  initial begin
    logic [15:0] cap_plan [10];
    in_valid            = 1'b0;
    in_code_unit        = '0;
    in_last_unit        = 1'b0;
    cfg_valid           = 1'b0;
    cfg_output_capacity = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: boundaries of each byte length, pairs and surrogate errors
    send_unit(16'h0000, 1'b0);
    send_unit(16'h0041, 1'b0);
    send_unit(16'h007F, 1'b0);
    send_unit(16'h0080, 1'b0);
    send_unit(16'h07FF, 1'b0);
    send_unit(16'h0800, 1'b0);
    send_unit(16'hFFFF, 1'b0);
    send_unit(HI_SURR_MIN, 1'b0);
    send_unit(LO_SURR_MIN, 1'b0);
    send_unit(HI_SURR_MAX, 1'b0);
    send_unit(LO_SURR_MAX, 1'b0);
    // lone low surrogate
    send_unit(LO_SURR_MIN, 1'b0);
    // broken pairs: plain unit, another high, then zero after a high
    send_unit(HI_SURR_MIN, 1'b0);
    send_unit(16'h0041, 1'b0);
    send_unit(HI_SURR_MAX, 1'b0);
    send_unit(HI_SURR_MIN, 1'b0);
    send_unit(16'hE000, 1'b0);
    send_unit(HI_SURR_MIN, 1'b0);
    send_unit(16'h0000, 1'b0);
    // high surrogate on the last unit
    send_unit(16'hD83D, 1'b1);
    settle();

    // zero capacity: every character skipped
    write_capacity(16'h0000);
    send_unit(16'h0041, 1'b0);
    send_unit(16'h00E9, 1'b1);
    settle();

    // tight capacity: a character that does not fit is skipped, later ones fill
    write_capacity(16'd5);
    send_unit(16'h0041, 1'b0);
    send_unit(16'h4E2D, 1'b0);
    send_unit(16'h00E9, 1'b0);
    send_unit(16'h0042, 1'b0);
    send_unit(16'h0043, 1'b1);
    settle();

    // random strings over a range of capacities, extremes included
    cap_plan = '{16'hFFFF, 16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd6,
                 16'($urandom_range(7, 40)), 16'($urandom_range(16'h100, 16'hFFFE)),
                 16'hFFFF};
    for (int p = 0; p < 10; p++) begin
      write_capacity(cap_plan[p]);
      fast_sender   = ($urandom_range(0, 3) == 0);
      fast_receiver = ($urandom_range(0, 3) == 0);
      if (p == 9) begin
        // back up the block: receiver holds off while units keep coming
        fast_sender   = 1'b1;
        hold_receiver = 1'b1;
      end
      random_string_units(PHASE_UNITS);
      settle();
    end

    $display("run covered %0d code units and %0d utf-8 bytes under %0d capacity writes",
             units_seen, bytes_seen, capacity_writes);
    $display("capacities from 0 to 65535, surrogate pairs, broken pairs and a long output stall");
    if (mismatch_count == 0 && bytes_pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // run limit, well beyond the slowest legal run
  initial begin
    #5000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
